[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the frame encoder.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

[rtl/wsfe_pkg.sv]
// Types, constants and helpers of the WebSocket frame encoder.
// No dependencies; used by every module of the block.
`default_nettype none
package wsfe_pkg;

   // command codes of an input item
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // length codes of the second header byte
   localparam logic [6:0]  LEN_CODE_16  = 7'd126;
   localparam logic [6:0]  LEN_CODE_64  = 7'd127;
   localparam logic [62:0] LEN_DIRECT_LIMIT = 63'd126;
   localparam logic [62:0] LEN_16_LIMIT     = 63'd65536;

   // extended length and key byte counts
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] EXT_NONE = 4'd0;
   localparam logic [STEP_W-1:0] EXT_16   = 4'd2;
   localparam logic [STEP_W-1:0] EXT_64   = 4'd8;
   localparam logic [STEP_W-1:0] KEY_BYTES = 4'd4;

   // descriptor queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic        cmd;
      logic [3:0]  opcode;
      logic        fin;
      logic [62:0] payload_len;
      logic [31:0] mask_key;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // one classified item: a payload byte (already masked when masking is on), or a header run
   typedef struct packed {
      logic [7:0]        byte0;      // payload byte or FIN/opcode byte
      logic [7:0]        byte1;      // mask flag and length code
      logic [STEP_W-1:0] len_ext;    // extended length bytes
      logic [STEP_W-1:0] last_step;  // index of the final byte of the run
      logic [62:0]       len;
      logic [31:0]       key;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // key byte idx, most significant byte first
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

[rtl/wsfe_front.sv]
// Front end: classifies accepted items, tracks key state, masks payload bytes.
// Depends on wsfe_pkg.
`default_nettype none
module wsfe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wsfe_pkg::req_type req_data,
   input  wire logic              accept,
   input  wire logic              mask_enable,
   output wsfe_pkg::desc_type     desc
);

   logic [31:0] key_store_ff, key_store_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   always_comb begin
      key_store_in = key_store_ff;
      key_idx_in   = key_idx_ff;
      if (accept) begin
         if (req_data.cmd == wsfe_pkg::CMD_START) begin
            key_store_in = req_data.mask_key;
            key_idx_in   = 2'd0;
         end else begin
            key_idx_in = key_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_store_ff <= '0;
         key_idx_ff   <= '0;
      end else begin
         key_store_ff <= key_store_in;
         key_idx_ff   <= key_idx_in;
      end
   end

   always_comb begin
      logic [6:0]                  code;
      logic [wsfe_pkg::STEP_W-1:0] ext;
      logic [wsfe_pkg::STEP_W-1:0] key_n;
      if (req_data.payload_len < wsfe_pkg::LEN_DIRECT_LIMIT) begin
         code = req_data.payload_len[6:0];
         ext  = wsfe_pkg::EXT_NONE;
      end else if (req_data.payload_len < wsfe_pkg::LEN_16_LIMIT) begin
         code = wsfe_pkg::LEN_CODE_16;
         ext  = wsfe_pkg::EXT_16;
      end else begin
         code = wsfe_pkg::LEN_CODE_64;
         ext  = wsfe_pkg::EXT_64;
      end
      key_n = mask_enable ? wsfe_pkg::KEY_BYTES : '0;

      desc.len = req_data.payload_len;
      desc.key = req_data.mask_key;
      if (req_data.cmd == wsfe_pkg::CMD_DATA) begin
         desc.byte0     = req_data.data_byte
                        ^ (mask_enable ? wsfe_pkg::key_byte(key_store_ff, key_idx_ff) : 8'h00);
         desc.byte1     = '0;
         desc.len_ext   = wsfe_pkg::EXT_NONE;
         desc.last_step = '0;
      end else begin
         desc.byte0     = {req_data.fin, 3'b000, req_data.opcode};
         desc.byte1     = {mask_enable, code};
         desc.len_ext   = ext;
         desc.last_step = 4'd1 + ext + key_n;
      end
   end

endmodule
`default_nettype wire

[rtl/wsfe_queue.sv]
// Short descriptor queue between the front and back ends.
// Depends on wsfe_pkg.
`default_nettype none
module wsfe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire wsfe_pkg::desc_type push_desc,
   input  wire logic               pop,
   output wsfe_pkg::desc_type      head,
   output wsfe_pkg::q_stat_type    stat
);

   wsfe_pkg::desc_type slot_ff [wsfe_pkg::Q_DEPTH];
   logic [wsfe_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [wsfe_pkg::Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [wsfe_pkg::Q_PTR_W-1:0] ptr_next(
      input logic [wsfe_pkg::Q_PTR_W-1:0] p);
      logic [wsfe_pkg::Q_PTR_W-1:0] n;
      if (p == wsfe_pkg::Q_PTR_W'(wsfe_pkg::Q_DEPTH - 1)) n = '0;
      else                                                 n = p + 1'b1;
      return n;
   endfunction

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == wsfe_pkg::Q_CNT_W'(wsfe_pkg::Q_DEPTH));
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_desc;
   end

endmodule
`default_nettype wire

[rtl/wsfe_back.sv]
// Back end: walks a descriptor byte by byte into the output register.
// Depends on wsfe_pkg.
`default_nettype none
module wsfe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wsfe_pkg::desc_type desc,
   input  wire logic               desc_valid,
   output logic                    desc_pop,
   input  wire logic               rsp_pop,
   output wsfe_pkg::rsp_type       rsp_data,
   output logic                    rsp_empty
);

   logic [wsfe_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        out_valid_ff, out_valid_in;
   wsfe_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        emit;
   logic                        last;

   assign emit      = desc_valid && (!out_valid_ff || rsp_pop);
   assign last      = (step_ff == desc.last_step);
   assign desc_pop  = emit && last;
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !out_valid_ff;

   // byte selection for the current step
   always_comb begin
      logic [63:0]                 len64;
      logic [wsfe_pkg::STEP_W-1:0] j, sh_w, k_w;
      logic [2:0]                  sh;
      logic [7:0]                  b;
      len64 = {1'b0, desc.len};
      j     = step_ff - 4'd2;
      sh_w  = desc.len_ext - 4'd1 - j;
      sh    = sh_w[2:0];
      k_w   = step_ff - 4'd2 - desc.len_ext;
      if (step_ff == 4'd0)                      b = desc.byte0;
      else if (step_ff == 4'd1)                 b = desc.byte1;
      else if (step_ff < 4'd2 + desc.len_ext)   b = len64[{sh, 3'b000} +: 8];
      else                                      b = wsfe_pkg::key_byte(desc.key, k_w[1:0]);
      rsp_in.out_byte    = b;
      rsp_in.last_of_run = last;
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         step_in      = last ? '0 : step_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

[rtl/websocket_frame_encoder_core.sv]
// Top level of the WebSocket frame encoder: front end, descriptor queue, back end.
// Depends on wsfe_pkg, wsfe_front, wsfe_queue, wsfe_back and assert_macros.svh.
//
//   channel  ports                          handshake
//   -------  -----------------------------  -------------------------------
//   input    req_push req_full req_data     item taken: push && !full
//   result   rsp_pop rsp_empty rsp_data     item taken: pop && !empty
//   config   csr_valid csr_ready csr_wdata  write: valid && ready (ready = 1)
//
// A payload item gives one result and streams at one item per cycle while results are popped.
// A start item gives 2 to 14 header bytes, one per cycle out of the back end while
// the output is popped; the front end's last_step sets the byte count.
// The two-entry descriptor queue lets the input take another item while a header drains.
// Synchronous reset empties the queue and output register, clears the key.
// An output stall holds the back end; the front stalls only when the queue fills.
`default_nettype none
`include "assert_macros.svh"
module websocket_frame_encoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   // input items
   input  wire logic              req_push,
   input  wire wsfe_pkg::req_type req_data,
   output logic                   req_full,
   // result items
   input  wire logic              rsp_pop,
   output wsfe_pkg::rsp_type      rsp_data,
   output logic                   rsp_empty,
   // mask_enable register
   input  wire logic              csr_valid,
   input  wire logic              csr_wdata,
   output logic                   csr_ready
);

   logic                 mask_enable_ff, mask_enable_in;
   logic                 accept;
   logic                 q_pop;
   wsfe_pkg::desc_type   new_desc;
   wsfe_pkg::desc_type   head_desc;
   wsfe_pkg::q_stat_type q_stat;

   // register writes always taken; user keeps the block idle when they arrive; not enforced
   assign csr_ready      = 1'b1;
   assign mask_enable_in = (csr_valid && csr_ready) ? csr_wdata : mask_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_enable_ff <= 1'b0;
      end else begin
         mask_enable_ff <= mask_enable_in;
      end
   end

   assign req_full = q_stat.full;
   assign accept   = req_push && !req_full;

   // front: classify, keep key and key index, mask payload bytes
   wsfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .accept      (accept),
      .mask_enable (mask_enable_ff),
      .desc        (new_desc)
   );

   wsfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (new_desc),
      .pop       (q_pop),
      .head      (head_desc),
      .stat      (q_stat)
   );

   // back: one byte per cycle into the output register while the output is not stalled
   wsfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc       (head_desc),
      .desc_valid (!q_stat.empty),
      .desc_pop   (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty)
   );

   // back end retires only a descriptor that is present
   `ASSERT_NEVER(a_pop_empty_queue, clock, reset, q_pop && q_stat.empty, "queue popped while empty")
   // queue status is never both full and empty
   `ASSERT_NEVER(a_queue_stat, clock, reset, q_stat.full && q_stat.empty, "queue full and empty")
   // the final byte of a run lands in the output register
   `ASSERT_CLK(a_last_lands, clock, reset, q_pop |=> (!rsp_empty && rsp_data.last_of_run), "last byte lost")
   // reset leaves no result pending
   `ASSERT_CLK(a_reset_empty, clock, 1'b0, reset |=> rsp_empty, "result pending after reset")

endmodule
`default_nettype wire

[sim/websocket_frame_encoder_core_tb.sv]
// Self-checking testbench of websocket_frame_encoder_core: directed and random items, with
// every result byte checked against a frame predictor kept in the testbench.
// Depends on wsfe_pkg and the encoder RTL only.
module websocket_frame_encoder_core_tb;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 16;       // well past the deepest header run in flight
   localparam int LIMIT_CYCLES  = 5_000_000;
   localparam int DRAIN_LIMIT   = 200_000;
   localparam int LONG_HOLD     = 400;      // receiver hold-off that fills the block
   localparam int PHASE_ITEMS   = 70;
   localparam int NUM_PHASES    = 6;
   localparam int MAX_REPORTS   = 10;
   localparam logic [5:0]  PHASE_MASK = 6'b101101;   // mask_enable per random phase
   localparam logic [62:0] LEN_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;

   // Frame predictor and store of expected output bytes.
   class frame_scoreboard;
      bit                mask_en;
      logic [31:0]       key;
      logic [1:0]        key_idx;
      wsfe_pkg::rsp_type expected_q[$];
      int                errors, checked, items, starts, payload_bytes, masked_starts;
      int                len_kind[3];

      function void note_item(wsfe_pkg::req_type r);
         logic [7:0]        run[$];
         logic [63:0]       len64;
         wsfe_pkg::rsp_type e;
         items++;
         if (r.cmd == wsfe_pkg::CMD_DATA) begin
            // index advances even with masking off
            e.out_byte    = r.data_byte ^ (mask_en ? key[8*(3-int'(key_idx)) +: 8] : 8'h00);
            e.last_of_run = 1'b1;
            key_idx       = key_idx + 2'd1;
            expected_q.push_back(e);
            payload_bytes++;
         end else begin
            key     = r.mask_key;
            key_idx = 2'd0;
            starts++;
            len64 = {1'b0, r.payload_len};
            run.push_back({r.fin, 3'b000, r.opcode});
            if (r.payload_len < wsfe_pkg::LEN_DIRECT_LIMIT) begin
               run.push_back({mask_en, r.payload_len[6:0]});
               len_kind[0]++;
            end else if (r.payload_len < wsfe_pkg::LEN_16_LIMIT) begin
               run.push_back({mask_en, wsfe_pkg::LEN_CODE_16});
               run.push_back(len64[15:8]);
               run.push_back(len64[7:0]);
               len_kind[1]++;
            end else begin
               run.push_back({mask_en, wsfe_pkg::LEN_CODE_64});
               for (int i = 7; i >= 0; i--) run.push_back(len64[8*i +: 8]);
               len_kind[2]++;
            end
            if (mask_en) begin
               for (int i = 3; i >= 0; i--) run.push_back(key[8*i +: 8]);
               masked_starts++;
            end
            foreach (run[i]) begin
               e.out_byte    = run[i];
               e.last_of_run = (i == run.size() - 1);
               expected_q.push_back(e);
            end
         end
      endfunction

      function void check_result(wsfe_pkg::rsp_type got);
         wsfe_pkg::rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            report_bad("result with nothing expected", e, got);
            return;
         end
         e = expected_q.pop_front();
         if (got.out_byte !== e.out_byte || got.last_of_run !== e.last_of_run)
            report_bad("wrong result", e, got);
      endfunction

      function void report_bad(string what, wsfe_pkg::rsp_type e, wsfe_pkg::rsp_type got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s at result %0d: expected byte %02h last %b, got byte %02h last %b",
                     $time, what, checked, e.out_byte, e.last_of_run,
                     got.out_byte, got.last_of_run);
      endfunction
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   wsfe_pkg::req_type req_data  = '0;
   logic              req_full;
   logic              rsp_pop   = 1'b0;
   wsfe_pkg::rsp_type rsp_data;
   logic              rsp_empty;
   logic              csr_valid = 1'b0;
   logic              csr_wdata = 1'b0;
   logic              csr_ready;

   frame_scoreboard sb = new();

   bit req_gaps_on  = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   int hold_request = 0;
   int long_holds   = 0;

   websocket_frame_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Everything is driven at the falling edge, so at the rising edge these reads see
   // settled values. Register write first, then input item, then result.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.mask_en = csr_wdata;
         if (req_push && !req_full) sb.note_item(req_data);
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_data);
      end
   end

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int rand_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Random item of the given command; fields the block ignores are random too.
   // Lengths lean toward each length code and its edges.
   function automatic wsfe_pkg::req_type rand_req(logic cmd);
      wsfe_pkg::req_type r;
      int                sel;
      r.cmd       = cmd;
      r.opcode    = 4'($urandom);
      r.fin       = 1'($urandom);
      r.mask_key  = $urandom;
      r.data_byte = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 45)      r.payload_len = 63'($urandom_range(0, 125));
      else if (sel < 70) r.payload_len = 63'($urandom_range(126, 65535));
      else if (sel < 85) r.payload_len = 63'($urandom) + 63'd65536;
      else if (sel < 95) r.payload_len = 63'({$urandom, $urandom});
      else begin
         case ($urandom_range(0, 4))
            0:       r.payload_len = 63'd125;
            1:       r.payload_len = 63'd126;
            2:       r.payload_len = 63'd65535;
            3:       r.payload_len = 63'd65536;
            default: r.payload_len = LEN_MAX;
         endcase
      end
      return r;
   endfunction

   // Offer one item, hold it until taken, then maybe leave a gap.
   task automatic push_item(wsfe_pkg::req_type r);
      int g;
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (req_gaps_on) begin
         g = rand_gap();
         if (g > 0) begin
            req_push <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   endtask

   task automatic send_start(logic [3:0] op, logic fin, logic [62:0] len, logic [31:0] key);
      wsfe_pkg::req_type r;
      r             = rand_req(wsfe_pkg::CMD_START);
      r.opcode      = op;
      r.fin         = fin;
      r.payload_len = len;
      r.mask_key    = key;
      push_item(r);
   endtask

   task automatic send_byte(logic [7:0] data);
      wsfe_pkg::req_type r;
      r           = rand_req(wsfe_pkg::CMD_DATA);
      r.data_byte = data;
      push_item(r);
   endtask

   // Stop offering and wait for every outstanding byte, then a little more so the
   // block is truly quiet.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mask(logic v);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Result side: random pop pattern, plus a long hold-off on request.
   initial begin : result_taker
      int hold;
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_pop     <= 1'b0;
            repeat (hold) @(negedge clock);
            long_holds++;
         end
         gap = rsp_gaps_on ? rand_gap() : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   initial begin : stimulus
      wsfe_pkg::req_type r;
      int                budget;
      int                n;
      bit                mid_drained;
      mid_drained = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Masking off after reset: payload before any start uses the zero key.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_start(4'h0, 1'b0, 63'd0, 32'hA5C3_0F96);
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_start(4'hF, 1'b1, 63'd125, 32'hFFFF_FFFF);
      send_start(4'h1, 1'b1, 63'd126, 32'h0000_0000);
      send_start(4'h2, 1'b0, 63'd65535, 32'h1234_5678);
      send_byte(8'h11);
      send_byte(8'h22);

      // Turn masking on in the middle of a frame: the index carries on at two.
      wait_idle();
      write_mask(1'b1);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(8'h55);
      send_start(4'h8, 1'b1, 63'd65536, 32'hFFFF_FFFF);
      send_start(4'h9, 1'b0, LEN_MAX, 32'h0000_0000);
      // more payload than the length says; masking keeps wrapping
      send_start(4'hA, 1'b1, 63'd3, 32'h9E37_79B9);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h01);
      send_byte(8'h80);
      send_start(4'h1, 1'b1, 63'd0, $urandom);
      send_start(4'h2, 1'b1, 63'd1, $urandom);
      send_byte(8'h7E);

      // Random phases, each under its own register setting and pacing. Mostly
      // well-formed frames (header, then its payload), some stray items mixed in.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_mask(PHASE_MASK[p]);
         req_gaps_on = (p != 0 && p != 2);
         rsp_gaps_on = (p != 0 && p != 4);
         // the sender keeps pushing while results back up behind the stall
         if (p == 2) hold_request = LONG_HOLD;
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            if ($urandom_range(0, 9) == 0) begin
               push_item(rand_req(1'($urandom)));
               budget--;
            end else begin
               r = rand_req(wsfe_pkg::CMD_START);
               n = (r.payload_len <= 63'd12) ? int'(r.payload_len) : $urandom_range(0, 12);
               if ($urandom_range(0, 6) == 0) n = $urandom_range(0, 6);
               push_item(r);
               budget--;
               repeat (n) begin
                  push_item(rand_req(wsfe_pkg::CMD_DATA));
                  budget--;
               end
            end
            // sender pauses until the block has handed out everything
            if (p == NUM_PHASES - 1 && !mid_drained && budget < PHASE_ITEMS / 2) begin
               wait_idle();
               mid_drained = 1'b1;
            end
         end
      end

      wait_idle();
      if (sb.expected_q.size() != 0) begin
         $display("%0d expected result bytes never arrived", sb.expected_q.size());
         sb.errors += sb.expected_q.size();
      end
      $display("Covered %0d items: %0d headers (%0d masked; %0d short, %0d 16-bit, %0d 64-bit),",
               sb.items, sb.starts, sb.masked_starts, sb.len_kind[0], sb.len_kind[1],
               sb.len_kind[2]);
      $display("%0d payload bytes; checked %0d result bytes, %0d mismatches, %0d long hold-offs",
               sb.payload_bytes, sb.checked, sb.errors, long_holds);
      if (sb.errors == 0) begin
         $display("[websocket_frame_encoder_core] OK");
      end else begin
         $display("[websocket_frame_encoder_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("Run timed out");
      $display("[websocket_frame_encoder_core] ERROR");
      $finish;
   end

endmodule

[websocket_frame_encoder_core.f]
+incdir+rtl
rtl/wsfe_pkg.sv
rtl/wsfe_front.sv
rtl/wsfe_queue.sv
rtl/wsfe_back.sv
rtl/websocket_frame_encoder_core.sv
sim/websocket_frame_encoder_core_tb.sv
